[rtl/ttd_pkg.sv]
`timescale 1ns / 1ps

package ttd_pkg;

   localparam logic [2:0] OP_TICK          = 3'd0;
   localparam logic [2:0] OP_SET_PERIODIC  = 3'd1;
   localparam logic [2:0] OP_SET_ONCE      = 3'd2;
   localparam logic [2:0] OP_DISABLE       = 3'd3;
   localparam logic [2:0] OP_REQUEST       = 3'd4;
   localparam logic [2:0] OP_CLEAR_TIMEOUT = 3'd5;
   localparam logic [2:0] OP_LOAD_FLAGS    = 3'd6;

   localparam logic [1:0] REASON_PERIODIC = 2'd0;
   localparam logic [1:0] REASON_ONCE     = 2'd1;
   localparam logic [1:0] REASON_TIMEOUT  = 2'd2;
   localparam logic [1:0] REASON_EVENT    = 2'd3;

   // bit positions inside the flag field
   localparam int FLAG_DISABLED     = 0;
   localparam int FLAG_RUN_ONCE     = 1;
   localparam int FLAG_PERIODIC_OFF = 2;
   localparam int FLAG_TIMEOUT_TYPE = 3;
   localparam int FLAG_REQUEST      = 4;

   localparam int RUN_TASK_W = 6;

   typedef struct packed {
      logic [4:0]  flags;
      logic [31:0] period;
      logic [31:0] count;
   } entry_type;

   localparam entry_type RESET_ENTRY = '{flags: 5'b00001, period: 32'd0, count: 32'd0};

endpackage

[rtl/tick_task_dispatcher.sv]
`timescale 1ns / 1ps
// Channel  Direction  Signals
// req      in         req_valid/req_ready, opcode, task_index, elapsed/period ticks, load flags
// rsp      out        rsp_valid/rsp_ready, run_task, run_reason, last_dispatch
//
// A tick walks the task table, one entry per cycle while the result side does not
// stall, through the read / write-back path of the task memory. Other commands
// read the entry, then write it back.
// Reset clears per-entry valid bits at once; an unwritten entry reads as disabled.
// A stalled result holds the walk on the current entry until the output frees up.
module tick_task_dispatcher #(
   parameter int NUM_TASKS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_task_index,
   input  logic [31:0] req_elapsed_ticks,
   input  logic [31:0] req_period_ticks,
   input  logic        req_load_periodic_off,
   input  logic        req_load_timeout_type,
   input  logic        req_load_run_once,
   input  logic        req_load_disabled,
   input  logic        req_load_request,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_run_task,
   output logic [1:0]  rsp_run_reason,
   output logic        rsp_last_dispatch
);
   import ttd_pkg::*;

   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EVAL  = 2'd1;
   localparam logic [1:0] S_CMD   = 2'd2;
   localparam logic [1:0] S_FLUSH = 2'd3;

   entry_type mem [NUM_TASKS];

   logic [NUM_TASKS-1:0] valid_ff;
   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  eval_ff, eval_in;
   logic [IDX_W-1:0]  rd_addr;
   entry_type         rd_data_ff;
   logic              rd_valid_ff;
   logic              wr_en;
   entry_type         wr_data;

   logic [2:0]        cmd_op_ff;
   logic [IDX_W-1:0]  cmd_idx_ff;
   logic [31:0]       cmd_elapsed_ff;
   logic [31:0]       cmd_period_ff;
   logic [4:0]        cmd_load_ff;

   logic              pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]  pend_task_ff, pend_task_in;
   logic [1:0]        pend_reason_ff, pend_reason_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_task_ff, rsp_task_in;
   logic [1:0]        rsp_reason_ff, rsp_reason_in;
   logic              rsp_last_ff, rsp_last_in;

   entry_type         cur;
   logic [31:0]       cnt_sum;
   logic              due;
   logic              dispatch;
   logic [1:0]        reason;
   logic              out_free;
   logic              advance;
   logic              eval_last;
   logic              accept;
   logic              in_range;
   logic              start_tick;
   logic              start_cmd;

   function automatic logic [IDX_W-1:0] wr_addr_of(input logic [IDX_W-1:0] scan_idx,
                                                   input logic [IDX_W-1:0] cmd_idx);
      wr_addr_of = (state_ff == S_EVAL) ? scan_idx : cmd_idx;
   endfunction

   assign req_ready         = (state_ff == S_IDLE);
   assign accept            = req_valid && req_ready;
   assign in_range          = req_task_index < 8'(NUM_TASKS);
   assign start_tick        = accept && (req_opcode == OP_TICK) && (req_elapsed_ticks != 32'd0);
   assign start_cmd         = accept && (req_opcode inside {[OP_SET_PERIODIC:OP_LOAD_FLAGS]})
                              && in_range;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_run_task      = RUN_TASK_W'(rsp_task_ff);
   assign rsp_run_reason    = rsp_reason_ff;
   assign rsp_last_dispatch = rsp_last_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign eval_last = (eval_ff == IDX_W'(NUM_TASKS - 1));

   // entry as read from the table, and its count after the tick adds its time
   assign cur     = rd_valid_ff ? rd_data_ff : RESET_ENTRY;
   assign cnt_sum = cur.count + cmd_elapsed_ff;
   assign due     = cnt_sum >= cur.period;

   always_comb begin
      dispatch = 1'b0;
      reason   = REASON_PERIODIC;
      if (!cur.flags[FLAG_DISABLED]) begin
         if (!cur.flags[FLAG_PERIODIC_OFF] && due) begin
            dispatch = 1'b1;
            reason   = REASON_PERIODIC;
         end else if (cur.flags[FLAG_RUN_ONCE] && due) begin
            dispatch = 1'b1;
            reason   = REASON_ONCE;
         end else if (cur.flags[FLAG_TIMEOUT_TYPE] && due) begin
            dispatch = 1'b1;
            reason   = REASON_TIMEOUT;
         end else if (cur.flags[FLAG_REQUEST]) begin
            dispatch = 1'b1;
            reason   = REASON_EVENT;
         end
      end
   end

   // hold the walk while a pending result cannot move to the output
   assign advance = !(dispatch && pend_valid_ff && !out_free);

   always_comb begin
      state_in       = state_ff;
      eval_in        = eval_ff;
      rd_addr        = eval_ff;
      wr_en          = 1'b0;
      wr_data        = cur;
      pend_valid_in  = pend_valid_ff;
      pend_task_in   = pend_task_ff;
      pend_reason_in = pend_reason_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_task_in    = rsp_task_ff;
      rsp_reason_in  = rsp_reason_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            rd_addr = req_task_index[IDX_W-1:0];
            eval_in = '0;
            if (start_tick) begin
               rd_addr  = '0;
               state_in = S_EVAL;
            end else if (start_cmd) begin
               state_in = S_CMD;
            end
         end
         S_EVAL: begin
            rd_addr = advance ? eval_ff + 1'b1 : eval_ff;
            if (advance) begin
               eval_in       = eval_ff + 1'b1;
               wr_en         = 1'b1;
               wr_data.count = cnt_sum;
               if (dispatch) begin
                  wr_data.count                = 32'd0;
                  wr_data.flags[FLAG_REQUEST]  = 1'b0;
                  if (cur.flags[FLAG_RUN_ONCE]) begin
                     wr_data.flags[FLAG_DISABLED] = 1'b1;
                  end
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_task_in   = pend_task_ff;
                     rsp_reason_in = pend_reason_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_task_in   = eval_ff;
                  pend_reason_in = reason;
               end
               if (eval_last) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_CMD: begin
            wr_en    = 1'b1;
            state_in = S_IDLE;
            case (cmd_op_ff)
               OP_SET_PERIODIC: begin
                  wr_data.flags[FLAG_RUN_ONCE] = 1'b0;
                  wr_data.flags[FLAG_DISABLED] = 1'b0;
                  wr_data.period               = cmd_period_ff;
                  wr_data.count                = 32'd0;
               end
               OP_SET_ONCE: begin
                  wr_data.flags[FLAG_RUN_ONCE] = 1'b1;
                  wr_data.flags[FLAG_DISABLED] = 1'b0;
                  wr_data.period               = cmd_period_ff;
                  wr_data.count                = 32'd0;
               end
               OP_DISABLE: begin
                  wr_data.flags[FLAG_DISABLED] = 1'b1;
               end
               OP_REQUEST: begin
                  wr_data.flags[FLAG_DISABLED] = 1'b0;
                  wr_data.flags[FLAG_REQUEST]  = 1'b1;
               end
               OP_CLEAR_TIMEOUT: begin
                  if (cur.flags[FLAG_TIMEOUT_TYPE]) begin
                     wr_data.flags[FLAG_DISABLED] = 1'b0;
                     wr_data.count                = 32'd0;
                  end
               end
               OP_LOAD_FLAGS: begin
                  wr_data.flags = cmd_load_ff;
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_task_in   = pend_task_ff;
               rsp_reason_in = pend_reason_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr_of(eval_ff, cmd_idx_ff)] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_op_ff      <= req_opcode;
         cmd_idx_ff     <= req_task_index[IDX_W-1:0];
         cmd_elapsed_ff <= req_elapsed_ticks;
         cmd_period_ff  <= req_period_ticks;
         cmd_load_ff    <= {req_load_request, req_load_timeout_type, req_load_periodic_off,
                            req_load_run_once, req_load_disabled};
      end
      pend_task_ff   <= pend_task_in;
      pend_reason_ff <= pend_reason_in;
      rsp_task_ff    <= rsp_task_in;
      rsp_reason_ff  <= rsp_reason_in;
      rsp_last_ff    <= rsp_last_in;
      eval_ff        <= eval_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= valid_ff[rd_addr];
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[wr_addr_of(eval_ff, cmd_idx_ff)] <= 1'b1;
         end
      end
   end

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("pending dispatch left over in idle");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> (eval_ff <= IDX_W'(NUM_TASKS - 1)))
      else $error("scan index past last task");

   a_scan_ends_in_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && eval_last && advance) |=> (state_ff == S_FLUSH))
      else $error("scan did not end in flush");

   a_stall_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && dispatch && pend_valid_ff && rsp_valid_ff && !rsp_ready)
      |-> (!wr_en && (eval_in == eval_ff)))
      else $error("task entry written back during output stall");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import ttd_pkg::*;

   localparam int NUM_TASKS = 16;
   localparam int RANDOM_CMDS = 386;
   localparam int DRAIN_CYCLES = 3 * NUM_TASKS + 20;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  index;
      logic [31:0] elapsed;
      logic [31:0] period;
      logic        p_off;
      logic        t_type;
      logic        once;
      logic        dis;
      logic        reqf;
   } command_type;

   typedef struct packed {
      logic [5:0] task_id;
      logic [1:0] reason;
      logic       last;
   } dispatch_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_run_task;
   logic [1:0]  rsp_run_reason;
   logic        rsp_last_dispatch;
   command_type cur_cmd = '0;

   // task table shadow
   logic [31:0] tick_count [NUM_TASKS];
   logic [31:0] period_len [NUM_TASKS];
   logic [4:0]  flag_bits  [NUM_TASKS];

   command_type  cmd_queue[$];
   dispatch_type dispatch_queue[$];
   int          mismatch_count = 0;
   int          cmds_sent = 0;
   int          cmds_total = 0;
   int          req_gap = 0;
   int          rsp_stall = 0;
   bit          req_burst = 1'b0;
   bit          rsp_burst = 1'b0;
   logic        req_fire = 1'b0;
   logic        rsp_fire = 1'b0;

   tick_task_dispatcher #(.NUM_TASKS(NUM_TASKS)) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (cur_cmd.opcode),
      .req_task_index        (cur_cmd.index),
      .req_elapsed_ticks     (cur_cmd.elapsed),
      .req_period_ticks      (cur_cmd.period),
      .req_load_periodic_off (cur_cmd.p_off),
      .req_load_timeout_type (cur_cmd.t_type),
      .req_load_run_once     (cur_cmd.once),
      .req_load_disabled     (cur_cmd.dis),
      .req_load_request      (cur_cmd.reqf),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_run_task          (rsp_run_task),
      .rsp_run_reason        (rsp_run_reason),
      .rsp_last_dispatch     (rsp_last_dispatch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      for (int t = 0; t < NUM_TASKS; t++) begin
         tick_count[t] = '0;
         period_len[t] = '0;
         flag_bits[t]  = 5'b0;
         flag_bits[t][FLAG_DISABLED] = 1'b1;
      end
   end

   function automatic int draw_wait(inout bit burst);
      if ($urandom_range(0, 29) == 0)
         burst = !burst;
      return burst ? 0 : $urandom_range(0, 6);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // apply one transfer to the shadow table and queue the dispatches it causes
   task automatic update_task_table(input command_type c);
      dispatch_type found[$];
      dispatch_type d;
      logic [4:0] f;
      logic       due;
      logic [1:0] why;
      int         t;
      if (c.opcode == OP_TICK) begin
         if (c.elapsed == 32'd0)
            return;
         for (t = 0; t < NUM_TASKS; t++)
            tick_count[t] += c.elapsed;
         for (t = 0; t < NUM_TASKS; t++) begin
            f = flag_bits[t];
            due = tick_count[t] >= period_len[t];
            if (f[FLAG_DISABLED])
               continue;
            if (!f[FLAG_PERIODIC_OFF] && due)
               why = REASON_PERIODIC;
            else if (f[FLAG_RUN_ONCE] && due)
               why = REASON_ONCE;
            else if (f[FLAG_TIMEOUT_TYPE] && due)
               why = REASON_TIMEOUT;
            else if (f[FLAG_REQUEST])
               why = REASON_EVENT;
            else
               continue;
            if (f[FLAG_RUN_ONCE])
               f[FLAG_DISABLED] = 1'b1;
            f[FLAG_REQUEST] = 1'b0;
            flag_bits[t] = f;
            tick_count[t] = '0;
            d.task_id = t[5:0];
            d.reason = why;
            d.last = 1'b0;
            found.push_back(d);
         end
         if (found.size() > 0)
            found[found.size() - 1].last = 1'b1;
         foreach (found[i])
            dispatch_queue.push_back(found[i]);
         return;
      end
      if (c.index >= NUM_TASKS)
         return;
      t = c.index;
      case (c.opcode)
         OP_SET_PERIODIC, OP_SET_ONCE: begin
            flag_bits[t][FLAG_DISABLED] = 1'b0;
            flag_bits[t][FLAG_RUN_ONCE] = (c.opcode == OP_SET_ONCE);
            period_len[t] = c.period;
            tick_count[t] = '0;
         end
         OP_DISABLE: flag_bits[t][FLAG_DISABLED] = 1'b1;
         OP_REQUEST: begin
            flag_bits[t][FLAG_DISABLED] = 1'b0;
            flag_bits[t][FLAG_REQUEST] = 1'b1;
         end
         OP_CLEAR_TIMEOUT: begin
            if (flag_bits[t][FLAG_TIMEOUT_TYPE]) begin
               tick_count[t] = '0;
               flag_bits[t][FLAG_DISABLED] = 1'b0;
            end
         end
         OP_LOAD_FLAGS: begin
            flag_bits[t][FLAG_PERIODIC_OFF] = c.p_off;
            flag_bits[t][FLAG_TIMEOUT_TYPE] = c.t_type;
            flag_bits[t][FLAG_RUN_ONCE]     = c.once;
            flag_bits[t][FLAG_DISABLED]     = c.dis;
            flag_bits[t][FLAG_REQUEST]      = c.reqf;
         end
         default: ;
      endcase
   endtask

   // load bits are {periodic_off, timeout_type, run_once, disabled, request}
   task automatic add_cmd(input logic [2:0] op, input logic [7:0] idx,
                          input logic [31:0] el, input logic [31:0] per,
                          input logic [4:0] lf);
      command_type c;
      c.opcode = op;
      c.index = idx;
      c.elapsed = el;
      c.period = per;
      {c.p_off, c.t_type, c.once, c.dis, c.reqf} = lf;
      cmd_queue.push_back(c);
   endtask

   task automatic add_random_cmd();
      int          pick;
      logic [2:0]  op;
      logic [7:0]  idx;
      logic [31:0] el;
      logic [31:0] per;
      logic [4:0]  lf;
      pick = $urandom_range(0, 99);
      idx = 8'($urandom_range(0, NUM_TASKS - 1));
      el = $urandom_range(1, 20);
      case ($urandom_range(0, 19))
         0: el = 32'd0;
         1: el = $urandom;
         2: el = 32'hFFFF_FFFF - $urandom_range(0, 15);
         default: ;
      endcase
      per = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
      lf = 5'($urandom);
      if ($urandom_range(0, 3) != 0)
         lf[1] = 1'b0;
      if (pick < 30)
         op = OP_TICK;
      else if (pick < 45)
         op = OP_SET_PERIODIC;
      else if (pick < 55)
         op = OP_SET_ONCE;
      else if (pick < 60)
         op = OP_DISABLE;
      else if (pick < 70)
         op = OP_REQUEST;
      else if (pick < 78)
         op = OP_CLEAR_TIMEOUT;
      else if (pick < 94)
         op = OP_LOAD_FLAGS;
      else if (pick < 97)
         op = OP_UNUSED;
      else begin
         op = 3'($urandom_range(1, 6));
         idx = 8'($urandom_range(NUM_TASKS, 255));
      end
      if (op == OP_TICK)
         idx = 8'($urandom);
      add_cmd(op, idx, el, per, lf);
   endtask

   initial begin
      add_cmd(OP_TICK, 0, 32'd0, 0, 5'b00000);
      add_cmd(OP_TICK, 0, 32'd5, 0, 5'b00000);
      add_cmd(OP_LOAD_FLAGS, 0, 0, 0, 5'b00000);
      add_cmd(OP_SET_PERIODIC, 1, 0, 32'hFFFF_FFFF, 5'b00000);
      add_cmd(OP_LOAD_FLAGS, 2, 0, 0, 5'b10100);
      add_cmd(OP_SET_ONCE, 2, 0, 32'd3, 5'b00000);
      add_cmd(OP_LOAD_FLAGS, 3, 0, 0, 5'b11010);
      add_cmd(OP_SET_PERIODIC, 3, 0, 32'd10, 5'b00000);
      add_cmd(OP_LOAD_FLAGS, 4, 0, 0, 5'b10001);
      add_cmd(OP_REQUEST, 5, 0, 0, 5'b00000);
      add_cmd(OP_LOAD_FLAGS, 15, 0, 0, 5'b11111);
      add_cmd(OP_UNUSED, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'b11111);
      add_cmd(OP_SET_PERIODIC, 8'(NUM_TASKS), 0, 0, 5'b00000);
      add_cmd(OP_REQUEST, 8'hFF, 0, 0, 5'b00000);
      add_cmd(OP_TICK, 0, 32'd4, 0, 5'b00000);
      add_cmd(OP_CLEAR_TIMEOUT, 3, 0, 0, 5'b00000);
      add_cmd(OP_CLEAR_TIMEOUT, 2, 0, 0, 5'b00000);
      add_cmd(OP_DISABLE, 0, 0, 0, 5'b00000);
      add_cmd(OP_TICK, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'b11111);
      add_cmd(OP_SET_PERIODIC, 15, 0, 32'hAAAA_AAAA, 5'b00000);
      add_cmd(OP_SET_ONCE, 14, 0, 32'h5555_5555, 5'b00000);
      add_cmd(OP_TICK, 0, 32'h8000_0000, 0, 5'b00000);
      add_cmd(OP_TICK, 0, 32'h8000_0000, 0, 5'b00000);
      add_cmd(OP_LOAD_FLAGS, 7, 0, 0, 5'b00010);
      repeat (RANDOM_CMDS)
         add_random_cmd();
      cmds_total = cmd_queue.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmds_sent < cmds_total || dispatch_queue.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // command driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_fire)
            req_gap = draw_wait(req_burst);
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (cmd_queue.size() > 0) begin
            cur_cmd <= cmd_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_fire <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         update_task_table(cur_cmd);
         cmds_sent++;
      end
   end

   // dispatch receiver: drop ready for a random gap, possibly none, after each transfer
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_fire)
            rsp_stall = draw_wait(rsp_burst);
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      dispatch_type want;
      rsp_fire <= !reset && rsp_valid && rsp_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (dispatch_queue.size() == 0) begin
            report_mismatch("unexpected dispatch, task", int'(rsp_run_task), -1);
         end else begin
            want = dispatch_queue.pop_front();
            if (rsp_run_task !== want.task_id)
               report_mismatch("run_task", int'(rsp_run_task), int'(want.task_id));
            if (rsp_run_reason !== want.reason)
               report_mismatch("run_reason", int'(rsp_run_reason), int'(want.reason));
            if (rsp_last_dispatch !== want.last)
               report_mismatch("last_dispatch", int'(rsp_last_dispatch), int'(want.last));
         end
      end
   end

endmodule

[filelist.f]
rtl/ttd_pkg.sv
rtl/tick_task_dispatcher.sv
test/tb_top.sv
